[rtl/hsv2rgb_pkg.sv]
// ============================================================================
// hsv2rgb_pkg
// Shared constants, codes and types for the HSV to RGB converter.
// ============================================================================
`default_nettype none

package hsv2rgb_pkg;

    // input field widths
    localparam int HUE_W = 10;
    localparam int PCT_W = 7;
    localparam int CHAN_W = 8;

    // reduced widths
    localparam int HUE_R_W = 9;   // 0..360
    localparam int DIST_W = 6;    // 0..60
    localparam int PROD_W = 14;   // up to 100*100
    localparam int NUM_W = 20;    // numerator over 600000
    localparam int Y_W = 24;      // numerator times 17
    localparam int RECIP_W = 25;
    localparam int MUL_W = Y_W + RECIP_W;
    localparam int RECIP_SHIFT = 40;

    localparam logic [HUE_W-1:0] FULL_HUE = HUE_W'(360);
    localparam logic [HUE_W-1:0] TWO_HUE = HUE_W'(720);
    localparam logic [PCT_W-1:0] FULL_PCT = PCT_W'(100);
    localparam logic [HUE_R_W-1:0] SEXT_DEG = HUE_R_W'(60);

    // 255/600000 reduces to 17/40000; floor(y/40000) == (y*RECIP) >> 40
    // for every y below 2^24
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(27487791);

    // hue sextants
    localparam logic [2:0] SEXT_RED_YEL = 3'd0;
    localparam logic [2:0] SEXT_YEL_GRN = 3'd1;
    localparam logic [2:0] SEXT_GRN_CYN = 3'd2;
    localparam logic [2:0] SEXT_CYN_BLU = 3'd3;
    localparam logic [2:0] SEXT_BLU_MAG = 3'd4;
    localparam logic [2:0] SEXT_MAG_RED = 3'd5;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } ld_t;

endpackage

`default_nettype wire

[rtl/hsv_to_rgb_converter.sv]
// ============================================================================
// hsv_to_rgb_converter
// Streaming HSV to RGB pixel converter, one word per clock unless stalled.
// ============================================================================
// Converts hue (whole degrees), saturation and value (percent) into 8-bit
// red, green and blue. Hue above 360 is taken mod 360 (360 itself maps like
// 0); saturation and value above 100 are taken mod 100. Each channel is
// floor(255*(component + offset)) computed exactly in integers over 600000,
// so the result matches a true-real computation truncated, never rounded.
// The block is a five-stage pipeline: range reduction; sextant, distance and
// the two percent products; chroma, secondary and offset multiplies;
// channel placement with offset add; reciprocal multiply for the final
// divide. A new word is taken every cycle unless backpressure has filled the
// pipe. Each stage holds its word only while the stage after it is full and
// stalled, so empty slots close up under backpressure and the input keeps
// accepting until the pipe is full.
// ============================================================================
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // hue[9:0], saturation[16:10], brightness[23:17]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    // stage valid bits, index 0 is the first stage
    logic [4:0] vld_reg, vld_next;
    logic [4:0] adv;
    logic [4:0] vin;
    hsv2rgb_pkg::ld_t ld;

    logic [2:0]                                 sext;
    logic [hsv2rgb_pkg::DIST_W-1:0]             hue_dist;
    logic [hsv2rgb_pkg::PROD_W-1:0]             sv;
    logic [hsv2rgb_pkg::PROD_W-1:0]             vn;
    logic [2:0][hsv2rgb_pkg::Y_W-1:0]           y;
    logic [2:0][hsv2rgb_pkg::CHAN_W-1:0]        chan;

    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        adv[4] = !vld_reg[4] || m_tready;
        for (int i = 3; i >= 0; i--)
            adv[i] = !vld_reg[i] || adv[i+1];
        vin = {vld_reg[3:0], s_tvalid};
        for (int i = 0; i < 5; i++)
            vld_next[i] = adv[i] ? vin[i] : vld_reg[i];
        ld.s1 = adv[0] && vin[0];
        ld.s2 = adv[1] && vin[1];
        ld.s3 = adv[2] && vin[2];
        ld.s4 = adv[3] && vin[3];
        ld.s5 = adv[4] && vin[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    hsv2rgb_prep u_prep (
        .clk        (clk),
        .ld         (ld),
        .hue        (s_tdata[9:0]),
        .saturation (s_tdata[16:10]),
        .brightness (s_tdata[23:17]),
        .sext       (sext),
        .hue_dist   (hue_dist),
        .sv         (sv),
        .vn         (vn)
    );

    hsv2rgb_mix u_mix (
        .clk      (clk),
        .ld       (ld),
        .sext     (sext),
        .hue_dist (hue_dist),
        .sv       (sv),
        .vn       (vn),
        .y        (y)
    );

    hsv2rgb_scale u_scale (
        .clk  (clk),
        .ld   (ld),
        .y    (y),
        .chan (chan)
    );

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[4];
    assign m_tdata  = {chan[2], chan[1], chan[0]};

endmodule

`default_nettype wire

[rtl/hsv2rgb_prep.sv]
// ============================================================================
// hsv2rgb_prep
// Stages 1-2: range reduction, then sextant, distance and percent products.
// ============================================================================
`default_nettype none

module hsv2rgb_prep (
    input  wire logic                              clk,
    input  wire hsv2rgb_pkg::ld_t                  ld,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]     saturation,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0]     brightness,
    output logic      [2:0]                        sext,
    output logic      [hsv2rgb_pkg::DIST_W-1:0]    hue_dist,
    output logic      [hsv2rgb_pkg::PROD_W-1:0]    sv,
    output logic      [hsv2rgb_pkg::PROD_W-1:0]    vn
);

    logic [hsv2rgb_pkg::HUE_R_W-1:0] h1_reg, h1_next;
    logic [hsv2rgb_pkg::PCT_W-1:0]   s1_reg, s1_next;
    logic [hsv2rgb_pkg::PCT_W-1:0]   v1_reg, v1_next;

    logic [2:0]                       sext_reg, sext_next;
    logic [hsv2rgb_pkg::DIST_W-1:0]   hue_dist_reg, hue_dist_next;
    logic [hsv2rgb_pkg::PROD_W-1:0]   sv_reg, sv_next;
    logic [hsv2rgb_pkg::PROD_W-1:0]   vn_reg, vn_next;
    logic [hsv2rgb_pkg::HUE_R_W-1:0]  k;

    // stage 1: hue mod 360 above 360, percents mod 100 above 100
    always_comb
    begin
        if (hue >= hsv2rgb_pkg::TWO_HUE)
            h1_next = hsv2rgb_pkg::HUE_R_W'(hue - hsv2rgb_pkg::TWO_HUE);
        else if (hue > hsv2rgb_pkg::FULL_HUE)
            h1_next = hsv2rgb_pkg::HUE_R_W'(hue - hsv2rgb_pkg::FULL_HUE);
        else
            h1_next = hsv2rgb_pkg::HUE_R_W'(hue);
        s1_next = (saturation > hsv2rgb_pkg::FULL_PCT) ?
                  saturation - hsv2rgb_pkg::FULL_PCT : saturation;
        v1_next = (brightness > hsv2rgb_pkg::FULL_PCT) ?
                  brightness - hsv2rgb_pkg::FULL_PCT : brightness;
    end

    // stage 2: position inside the 120-degree period, sextant, products
    always_comb
    begin
        if (h1_reg >= hsv2rgb_pkg::HUE_R_W'(3 * 2 * hsv2rgb_pkg::SEXT_DEG))
            k = h1_reg - hsv2rgb_pkg::HUE_R_W'(3 * 2 * hsv2rgb_pkg::SEXT_DEG);
        else if (h1_reg >= hsv2rgb_pkg::HUE_R_W'(2 * 2 * hsv2rgb_pkg::SEXT_DEG))
            k = h1_reg - hsv2rgb_pkg::HUE_R_W'(2 * 2 * hsv2rgb_pkg::SEXT_DEG);
        else if (h1_reg >= hsv2rgb_pkg::HUE_R_W'(2 * hsv2rgb_pkg::SEXT_DEG))
            k = h1_reg - hsv2rgb_pkg::HUE_R_W'(2 * hsv2rgb_pkg::SEXT_DEG);
        else
            k = h1_reg;

        if (k >= hsv2rgb_pkg::SEXT_DEG)
            hue_dist_next = hsv2rgb_pkg::DIST_W'(k - hsv2rgb_pkg::SEXT_DEG);
        else
            hue_dist_next = hsv2rgb_pkg::DIST_W'(hsv2rgb_pkg::SEXT_DEG - k);

        // hue of exactly 360 lands in the magenta-red sextant
        if (h1_reg < hsv2rgb_pkg::SEXT_DEG)
            sext_next = hsv2rgb_pkg::SEXT_RED_YEL;
        else if (h1_reg < hsv2rgb_pkg::HUE_R_W'(2 * hsv2rgb_pkg::SEXT_DEG))
            sext_next = hsv2rgb_pkg::SEXT_YEL_GRN;
        else if (h1_reg < hsv2rgb_pkg::HUE_R_W'(3 * hsv2rgb_pkg::SEXT_DEG))
            sext_next = hsv2rgb_pkg::SEXT_GRN_CYN;
        else if (h1_reg < hsv2rgb_pkg::HUE_R_W'(4 * hsv2rgb_pkg::SEXT_DEG))
            sext_next = hsv2rgb_pkg::SEXT_CYN_BLU;
        else if (h1_reg < hsv2rgb_pkg::HUE_R_W'(5 * hsv2rgb_pkg::SEXT_DEG))
            sext_next = hsv2rgb_pkg::SEXT_BLU_MAG;
        else
            sext_next = hsv2rgb_pkg::SEXT_MAG_RED;

        sv_next = hsv2rgb_pkg::PROD_W'(s1_reg) * hsv2rgb_pkg::PROD_W'(v1_reg);
        vn_next = hsv2rgb_pkg::PROD_W'(v1_reg) *
                  hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::FULL_PCT - s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            h1_reg <= h1_next;
            s1_reg <= s1_next;
            v1_reg <= v1_next;
        end
        if (ld.s2)
        begin
            sext_reg     <= sext_next;
            hue_dist_reg <= hue_dist_next;
            sv_reg       <= sv_next;
            vn_reg       <= vn_next;
        end
    end

    assign sext     = sext_reg;
    assign hue_dist = hue_dist_reg;
    assign sv       = sv_reg;
    assign vn       = vn_reg;

endmodule

`default_nettype wire

[rtl/hsv2rgb_mix.sv]
// ============================================================================
// hsv2rgb_mix
// Stages 3-4: chroma, secondary and offset, then channel placement.
// ============================================================================
`default_nettype none

module hsv2rgb_mix (
    input  wire logic                                 clk,
    input  wire hsv2rgb_pkg::ld_t                     ld,
    input  wire logic [2:0]                           sext,
    input  wire logic [hsv2rgb_pkg::DIST_W-1:0]       hue_dist,
    input  wire logic [hsv2rgb_pkg::PROD_W-1:0]       sv,
    input  wire logic [hsv2rgb_pkg::PROD_W-1:0]       vn,
    output logic      [2:0][hsv2rgb_pkg::Y_W-1:0]     y
);

    logic [hsv2rgb_pkg::NUM_W-1:0] c_reg, c_next;
    logic [hsv2rgb_pkg::NUM_W-1:0] x_reg, x_next;
    logic [hsv2rgb_pkg::NUM_W-1:0] m_reg, m_next;
    logic [2:0]                    sext_reg;

    logic [2:0][hsv2rgb_pkg::NUM_W-1:0] comp;
    logic [2:0][hsv2rgb_pkg::NUM_W-1:0] num;
    logic [2:0][hsv2rgb_pkg::Y_W-1:0]   y_reg, y_next;

    // stage 3: all terms over 600000
    always_comb
    begin
        c_next = hsv2rgb_pkg::NUM_W'(sv) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SEXT_DEG);
        x_next = hsv2rgb_pkg::NUM_W'(sv) *
                 hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SEXT_DEG - hsv2rgb_pkg::HUE_R_W'(hue_dist));
        m_next = hsv2rgb_pkg::NUM_W'(vn) * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::SEXT_DEG);
    end

    // stage 4: place components (index 0 red, 1 green, 2 blue), add offset, x17
    always_comb
    begin
        comp = '0;
        case (sext_reg)
            hsv2rgb_pkg::SEXT_RED_YEL: begin comp[0] = c_reg; comp[1] = x_reg; end
            hsv2rgb_pkg::SEXT_YEL_GRN: begin comp[0] = x_reg; comp[1] = c_reg; end
            hsv2rgb_pkg::SEXT_GRN_CYN: begin comp[1] = c_reg; comp[2] = x_reg; end
            hsv2rgb_pkg::SEXT_CYN_BLU: begin comp[1] = x_reg; comp[2] = c_reg; end
            hsv2rgb_pkg::SEXT_BLU_MAG: begin comp[0] = x_reg; comp[2] = c_reg; end
            default:                   begin comp[0] = c_reg; comp[2] = x_reg; end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            num[i]    = comp[i] + m_reg;
            y_next[i] = (hsv2rgb_pkg::Y_W'(num[i]) << 4) + hsv2rgb_pkg::Y_W'(num[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s3)
        begin
            c_reg    <= c_next;
            x_reg    <= x_next;
            m_reg    <= m_next;
            sext_reg <= sext;
        end
        if (ld.s4)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

`default_nettype wire

[rtl/hsv2rgb_scale.sv]
// ============================================================================
// hsv2rgb_scale
// Stage 5: divide each channel numerator by 40000 through a reciprocal.
// ============================================================================
`default_nettype none

module hsv2rgb_scale (
    input  wire logic                                 clk,
    input  wire hsv2rgb_pkg::ld_t                     ld,
    input  wire logic [2:0][hsv2rgb_pkg::Y_W-1:0]     y,
    output logic      [2:0][hsv2rgb_pkg::CHAN_W-1:0]  chan
);

    logic [2:0][hsv2rgb_pkg::MUL_W-1:0] prod_reg, prod_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = hsv2rgb_pkg::MUL_W'(y[i]) *
                           hsv2rgb_pkg::MUL_W'(hsv2rgb_pkg::RECIP);
            chan[i] = prod_reg[i][hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s5)
            prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking stream bench for the HSV to RGB pixel converter.
// ============================================================================
// A queue of pending pixels feeds a clocked driver on the slave side; a
// clocked monitor predicts the color of every word the block accepts and
// checks each output word, field by field, against the oldest prediction.
// The run starts with directed corners (range folding, sextant edges, gray
// and black), then three random phases with different idle mixes on each
// side. A long receiver hold-off in two phases fills the pipe so that the
// block must stall its input. A watchdog ends the run if no word moves
// for too long.
// ============================================================================

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // slave-side word, lowest field in the low bits
    typedef struct packed {
        logic [hsv2rgb_pkg::PCT_W-1:0] brightness;
        logic [hsv2rgb_pkg::PCT_W-1:0] saturation;
        logic [hsv2rgb_pkg::HUE_W-1:0] hue;
    } hsv_t;

    // master-side word, red in the low byte
    typedef struct packed {
        logic [hsv2rgb_pkg::CHAN_W-1:0] blue;
        logic [hsv2rgb_pkg::CHAN_W-1:0] green;
        logic [hsv2rgb_pkg::CHAN_W-1:0] red;
    } rgb_t;

    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 300;   // receiver hold-off used to fill the pipe
    localparam int DRAIN_CYCLES = 20;   // pipe is five deep; margin after last word
    localparam int REPORT_MAX = 10;
    localparam int PHASE_WORDS = 580;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // hue[9:0], saturation[16:10], brightness[23:17]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // red[7:0], green[15:8], blue[23:16]

    hsv_t pending_pixels[$];        // stimulus not yet offered
    rgb_t expected_colors[$];       // predictions for accepted words, oldest first

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;          // bumped by the sequencer to ask for a hold-off
    int mismatches = 0;

    hsv_to_rgb_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Color predictor. Everything is a numerator over 600000 (100*100*60),
    // so the channel math is exact and truncates like the spec asks.
    // ------------------------------------------------------------------------
    function automatic logic [hsv2rgb_pkg::CHAN_W-1:0] channel_level(int unsigned numer);
        longint unsigned scaled;
        scaled = (longint'(numer) * 255) / 600000;
        return scaled[hsv2rgb_pkg::CHAN_W-1:0];
    endfunction

    function automatic rgb_t predict_rgb(hsv_t px);
        int unsigned h, s, v, phase, hue_dist;
        int unsigned chroma, second, offset, rn, gn, bn;
        logic [2:0]  sext;
        rgb_t        color;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        // fold out-of-range inputs; exactly 360 / 100 are kept as they are
        if (h > 360) h = h % 360;
        if (s > 100) s = s % 100;
        if (v > 100) v = v % 100;

        // distance from the middle of the 120-degree period
        phase = h % 120;
        hue_dist = (phase >= 60) ? phase - 60 : 60 - phase;

        chroma = s * v * 60;
        second = s * v * (60 - hue_dist);
        offset = v * 6000 - chroma;

        // hue 360 lands in the last sextant with a zero secondary
        sext = (h >= 300) ? hsv2rgb_pkg::SEXT_MAG_RED : 3'(h / 60);
        case (sext)
            hsv2rgb_pkg::SEXT_RED_YEL: begin rn = chroma; gn = second; bn = 0;      end
            hsv2rgb_pkg::SEXT_YEL_GRN: begin rn = second; gn = chroma; bn = 0;      end
            hsv2rgb_pkg::SEXT_GRN_CYN: begin rn = 0;      gn = chroma; bn = second; end
            hsv2rgb_pkg::SEXT_CYN_BLU: begin rn = 0;      gn = second; bn = chroma; end
            hsv2rgb_pkg::SEXT_BLU_MAG: begin rn = second; gn = 0;      bn = chroma; end
            default:                   begin rn = chroma; gn = 0;      bn = second; end
        endcase

        color.red = channel_level(rn + offset);
        color.green = channel_level(gn + offset);
        color.blue = channel_level(bn + offset);
        return color;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: once a word is offered it stays up until taken. A new word is
    // offered only when the sender is not idling this cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_pixels
        hsv_t next_px;
        logic busy;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else begin
            busy = s_tvalid && !s_tready;
            if (!busy) begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_px = pending_pixels.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_px;
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off on request. The hold-off
    // is counted here so the sequencer only has to ask for it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_ready
        int hold_left;
        int hold_seen;
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else begin
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on input accept, check on output accept. Both happen
    // in this one process so a same-edge accept and result cannot race.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_colors
        rgb_t got;
        rgb_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                expected_colors.push_back(predict_rgb(hsv_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata);
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected word r=%0d g=%0d b=%0d",
                                 $realtime, got.red, got.green, got.blue);
                end
                else begin
                    want = expected_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: color mismatch exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge clk) begin : watchdog
        int quiet_cycles;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else begin
            quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_pixel(int unsigned h, int unsigned s, int unsigned v);
        hsv_t px;
        px.hue = hsv2rgb_pkg::HUE_W'(h);
        px.saturation = hsv2rgb_pkg::PCT_W'(s);
        px.brightness = hsv2rgb_pkg::PCT_W'(v);
        pending_pixels.push_back(px);
    endtask

    // mostly the full field range (folding, every bit), some in-range only,
    // some near the sextant edges
    task automatic add_random_pixels(int count);
        int unsigned h;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0, 1, 2, 3:
                    add_pixel($urandom_range(1023), $urandom_range(127), $urandom_range(127));
                4, 5:
                    add_pixel($urandom_range(360), $urandom_range(100), $urandom_range(100));
                default: begin
                    h = 60 * $urandom_range(6) + $urandom_range(2);
                    if ($urandom_range(1)) h = h + 360;
                    add_pixel(h, $urandom_range(100), $urandom_range(100));
                end
            endcase
        end
    endtask

    task automatic wait_pending_empty();
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    initial begin : run_test
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners
        add_pixel(0, 0, 0);           // black
        add_pixel(0, 0, 100);         // white, no chroma
        add_pixel(200, 0, 57);        // gray
        add_pixel(0, 100, 100);       // pure red
        add_pixel(120, 100, 100);     // pure green
        add_pixel(240, 100, 100);     // pure blue
        add_pixel(60, 100, 100);      // yellow, sextant edge
        add_pixel(180, 100, 100);
        add_pixel(300, 100, 100);
        add_pixel(59, 100, 100);      // just below each edge
        add_pixel(119, 77, 93);
        add_pixel(299, 100, 100);
        add_pixel(359, 100, 100);
        add_pixel(360, 100, 100);     // full turn kept, same as hue 0
        add_pixel(361, 100, 100);     // folds to 1
        add_pixel(720, 100, 100);     // folds to 0
        add_pixel(1023, 127, 127);    // every input bit high
        add_pixel(30, 101, 101);      // percent just over the top folds to 1
        add_pixel(90, 127, 127);      // folds to 27
        add_pixel(150, 100, 127);
        add_pixel(330, 50, 50);
        add_pixel(512, 64, 64);       // single high bits
        add_pixel(270, 1, 1);

        // phase one: sender idles lightly, receiver heavily
        send_idle_pct = 16;
        recv_idle_pct = 69;
        add_random_pixels(PHASE_WORDS);
        wait_pending_empty();

        // phase two: the other way round, with a long receiver hold-off
        send_idle_pct = 69;
        recv_idle_pct = 16;
        add_random_pixels(PHASE_WORDS);
        hold_requests++;
        wait_pending_empty();

        // phase three: full rate both sides, hold-off fills the pipe
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_pixels(PHASE_WORDS);
        hold_requests++;
        wait_pending_empty();

        while (s_tvalid || expected_colors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        // anything still expected here never came out
        mismatches += expected_colors.size();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_prep.sv
rtl/hsv2rgb_mix.sv
rtl/hsv2rgb_scale.sv
rtl/hsv_to_rgb_converter.sv
sim/tb_top.sv
